/* rtl/hnc_pkg.sv */
// ============================================================================
// hnc_pkg
// Shared types, codes and helpers of the Hamming nearest-codebook block.
// ============================================================================
`default_nettype none

package hnc_pkg;

  // Default sizes of the codebook.
  localparam int DEF_WORDS   = 16;
  localparam int DEF_ENTRIES = 64;

  // Fixed field widths of the input and result words.
  localparam int OP_W        = 2;
  localparam int IDX_W       = 4;
  localparam int DATA_W      = 64;
  localparam int STAT_W      = 2;
  localparam int OUT_CNT_W   = 7;
  localparam int OUT_IDX_W   = 6;
  localparam int OUT_DIST_W  = 11;
  localparam int POP_W       = 7;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_STREAM
  } state_t;

  // Input word payload.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  word_index;
    logic [DATA_W-1:0] word_data;
  } in_item_t;

  // Result word payload.
  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [OUT_CNT_W-1:0]  entry_count;
    logic [OUT_IDX_W-1:0]  best_index;
    logic [OUT_DIST_W-1:0] distance;
    logic [DATA_W-1:0]     clean_word;
    logic                  last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;          // input word accepted this cycle
    logic scan_start;    // clear scan counters and best-so-far
    logic scan_issue;    // read one store word for the distance scan
    logic stream_start;  // rewind the word counter for streaming
    logic stream_mode;   // read address points at the winning entry
    logic stream_load;   // move one clean word into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic starts_scan;   // current input is a final query word with entries present
    logic scan_last;     // the read issued now is the last word of the last entry
    logic pipe_empty;    // no scan read left in the distance pipeline
    logic rd_ok;         // store read data matches the current stream word
    logic stream_last;   // current stream word is the final word of the vector
  } dp_stat_t;

  // Population count of a 64-bit word as a balanced adder tree.
  function automatic logic [POP_W-1:0] popcount64(input logic [DATA_W-1:0] x);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    return {1'b0, l5[0]} + {1'b0, l5[1]};
  endfunction

endpackage

`default_nettype wire

/* rtl/hnc_ifs.sv */
// ============================================================================
// hnc_ifs
// Valid/ready channel interfaces for the input and result words.
// ============================================================================
`default_nettype none

interface hnc_in_if;
  import hnc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hnc_out_if;
  import hnc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/hnc_dp.sv */
// ============================================================================
// hnc_dp
// Datapath: codebook store, query buffer, distance pipeline, best-match
// tracking and the result register.
// ============================================================================
`default_nettype none

module hnc_dp #(
  parameter int WORDS   = hnc_pkg::DEF_WORDS,
  parameter int ENTRIES = hnc_pkg::DEF_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hnc_pkg::in_item_t  in_data,
  input  wire hnc_pkg::dp_cmd_t   cmd,
  output hnc_pkg::dp_stat_t       stat,
  output hnc_pkg::out_item_t      out_data
);
  import hnc_pkg::*;

  localparam int WB        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int EB        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CB        = $clog2(ENTRIES + 1);
  localparam int DB        = $clog2(WORDS * 64 + 2);
  localparam int AB        = EB + WB;
  localparam int MEM_DEPTH = ENTRIES * (2 ** WB);
  localparam int QB_DEPTH  = 2 ** WB;
  localparam logic [WB-1:0] LAST_W    = WB'(WORDS - 1);
  localparam logic [DB-1:0] DIST_INIT = DB'(WORDS * 64 + 1);

  // Storage.
  logic [DATA_W-1:0] store_mem [MEM_DEPTH];
  logic [DATA_W-1:0] qbuf_mem  [QB_DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] qdata_r;

  // Control and pipeline registers.
  logic [CB-1:0]    committed_r, committed_nxt;
  logic [EB-1:0]    e_r;
  logic [WB-1:0]    w_r;
  logic             rd_ok_r;
  logic             v1_r, v2_r;
  logic             lw1_r, lw2_r;
  logic [EB-1:0]    e1_r, e2_r;
  logic [POP_W-1:0] pc_r;
  logic [DB-1:0]    acc_r;
  logic [DB-1:0]    best_dist_r;
  logic [EB-1:0]    best_r;
  out_item_t        out_r, out_nxt;

  // Decoded input word.
  logic          is_clear, is_add, is_query;
  logic          idx_ok, is_final, full, empty;
  logic [WB-1:0] widx;
  logic          store_we, qbuf_we, load_single;
  logic [AB-1:0] waddr, raddr;
  logic [DB-1:0] sum;

  // Decode the input word against the codebook state.
  always_comb begin
    is_clear    = (in_data.operation == OP_CLEAR);
    is_add      = (in_data.operation == OP_ADD);
    is_query    = (in_data.operation == OP_QUERY);
    idx_ok      = (int'(in_data.word_index) < WORDS);
    widx        = WB'(in_data.word_index);
    is_final    = idx_ok && (widx == LAST_W);
    full        = (committed_r == CB'(ENTRIES));
    empty       = (committed_r == '0);
    store_we    = cmd.take && is_add && idx_ok && !full;
    qbuf_we     = cmd.take && is_query && idx_ok;
    waddr       = {EB'(committed_r), widx};
    raddr       = cmd.stream_mode ? {best_r, w_r} : {e_r, w_r};
    load_single = cmd.take && !stat.starts_scan;
  end

  // Committed entry count after the current input word.
  always_comb begin
    committed_nxt = committed_r;
    if (cmd.take && is_clear) begin
      committed_nxt = '0;
    end else if (store_we && is_final) begin
      committed_nxt = committed_r + CB'(1);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.starts_scan = is_query && is_final && !empty;
    stat.scan_last   = (w_r == LAST_W) && ((CB'(e_r) + CB'(1)) == committed_r);
    stat.pipe_empty  = !v1_r && !v2_r;
    stat.rd_ok       = rd_ok_r;
    stat.stream_last = (w_r == LAST_W);
  end

  // Codebook store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[waddr] <= in_data.word_data;
    end
    rdata_r <= store_mem[raddr];
  end

  // Query buffer, read in step with the store during a scan.
  always_ff @(posedge clk) begin
    if (qbuf_we) begin
      qbuf_mem[widx] <= in_data.word_data;
    end
    qdata_r <= qbuf_mem[w_r];
  end

  // Entry count, word/entry counters and stream read tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r <= '0;
      e_r         <= '0;
      w_r         <= '0;
      rd_ok_r     <= 1'b0;
    end else begin
      committed_r <= committed_nxt;
      rd_ok_r     <= !(cmd.stream_start || cmd.stream_load);
      if (cmd.scan_start) begin
        e_r <= '0;
        w_r <= '0;
      end else if (cmd.stream_start) begin
        w_r <= '0;
      end else if (cmd.scan_issue) begin
        if (w_r == LAST_W) begin
          w_r <= '0;
          e_r <= e_r + EB'(1);
        end else begin
          w_r <= w_r + WB'(1);
        end
      end else if (cmd.stream_load) begin
        w_r <= w_r + WB'(1);
      end
    end
  end

  // Distance pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_issue;
      v2_r <= v1_r;
    end
  end

  // Tags travel with the read, then the word distance is counted.
  always_ff @(posedge clk) begin
    lw1_r <= (w_r == LAST_W);
    e1_r  <= e_r;
    lw2_r <= lw1_r;
    e2_r  <= e1_r;
    pc_r  <= popcount64(rdata_r ^ qdata_r);
  end

  assign sum = acc_r + DB'(pc_r);

  // Accumulate per entry; a strictly smaller total replaces the best match.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      acc_r       <= '0;
      best_dist_r <= DIST_INIT;
      best_r      <= '0;
    end else if (v2_r) begin
      if (lw2_r) begin
        acc_r <= '0;
        if (sum < best_dist_r) begin
          best_dist_r <= sum;
          best_r      <= e2_r;
        end
      end else begin
        acc_r <= sum;
      end
    end
  end

  // Result register: single replies or one clean word per load.
  always_comb begin
    out_nxt = out_r;
    if (load_single) begin
      out_nxt.status      = STAT_OK;
      out_nxt.entry_count = OUT_CNT_W'(committed_nxt);
      out_nxt.best_index  = '0;
      out_nxt.distance    = '0;
      out_nxt.clean_word  = '0;
      out_nxt.last        = 1'b1;
      if (is_add && idx_ok && full) begin
        out_nxt.status = STAT_FULL;
      end else if (is_query && is_final && empty) begin
        out_nxt.status = STAT_EMPTY;
      end
    end else if (cmd.stream_load) begin
      out_nxt.status      = STAT_OK;
      out_nxt.entry_count = OUT_CNT_W'(committed_r);
      out_nxt.best_index  = OUT_IDX_W'(best_r);
      out_nxt.distance    = OUT_DIST_W'(best_dist_r);
      out_nxt.clean_word  = rdata_r;
      out_nxt.last        = (w_r == LAST_W);
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

`ifndef ASSERT_OFF
  // The entry count never runs past the codebook size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r <= CB'(ENTRIES))
    else $error("entry count exceeds codebook size");

  // A counted word distance always comes from a scan read in the cycle before.
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("distance stage valid without a preceding read");

  // A streamed load never directly follows another streamed load, so its read has settled.
  a_stream_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stream_load |-> !$past(cmd.stream_load))
    else $error("clean word loaded before its read settled");

  // No scan read is issued once streaming has begun.
  a_no_scan_stream: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stream_start |=> !v1_r)
    else $error("scan read still in flight during streaming");
`endif

endmodule

`default_nettype wire

/* rtl/hnc_ctrl.sv */
// ============================================================================
// hnc_ctrl
// Controller: sequences accept, distance scan, pipeline drain and streaming
// of the clean vector, and owns the result valid flag.
// ============================================================================
`default_nettype none

module hnc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire hnc_pkg::dp_stat_t stat,
  output hnc_pkg::dp_cmd_t       cmd
);
  import hnc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   load_single;

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    load_single = 1'b0;
    out_free    = !out_valid_r || out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          cmd.take = 1'b1;
          if (stat.starts_scan) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            load_single = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.stream_start = 1'b1;
          state_nxt        = ST_STREAM;
        end
      end
      ST_STREAM: begin
        cmd.stream_mode = 1'b1;
        if (stat.rd_ok && out_free) begin
          cmd.stream_load = 1'b1;
          if (stat.stream_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || load_single || cmd.stream_load;
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // A final query with entries moves straight into the scan.
  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |=> (state_r == ST_SCAN))
    else $error("scan did not start after final query word");

  // A drained pipeline hands over to streaming in the next cycle.
  a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && stat.pipe_empty) |=> (state_r == ST_STREAM))
    else $error("drain did not hand over to streaming");

  // Every streamed load raises the result valid flag.
  a_stream_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stream_load |=> out_valid_r)
    else $error("streamed word not presented");
`endif

endmodule

`default_nettype wire

/* rtl/hamming_nearest_codebook.sv */
// ============================================================================
// hamming_nearest_codebook
// Associative codebook of binary hypervectors with nearest-entry lookup by
// Hamming distance and streaming of the clean vector.
// ============================================================================
//
//   Channel   Dir   Word carries
//   in_ch     in    operation, word_index, word_data
//   out_ch    out   status, entry_count, best_index, distance, clean_word, last
//
// Clear, add and non-final query words give a single result; it is in the
// output register the cycle after acceptance.
// A final query word with N committed entries scans all N*WORDS stored words
// and then streams WORDS clean words: the codebook store has a single
// read port that delivers one 64-bit word per cycle.
// Reset clears the entry count and the controller; the store and the query
// buffer hold whatever was last written.
// A stalled result holds in the output register; the input waits while a
// query is scanned or streamed.
//
`default_nettype none

module hamming_nearest_codebook #(
  parameter int WORDS   = hnc_pkg::DEF_WORDS,
  parameter int ENTRIES = hnc_pkg::DEF_ENTRIES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hnc_in_if.sink     in_ch,
  hnc_out_if.source  out_ch
);
  import hnc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  hnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and distance arithmetic.
  hnc_dp #(
    .WORDS   (WORDS),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_ch.data)
  );

endmodule

`default_nettype wire
